[rtl/lpef_pkg.sv]
// Shared constants and widths for the line position error filter.
`timescale 1ns / 1ps
`default_nettype none
package lpef_pkg;

  localparam int unsigned PatW     = 8;   // sensor channels
  localparam int unsigned IdxW     = 3;   // channel index
  localparam int unsigned CntW     = 4;   // black channel count, 0..8
  localparam int unsigned SumW     = 5;   // index sum, 0..28
  localparam int unsigned DvdW     = SumW + 8;  // sum in Q8
  localparam int unsigned StepW    = 4;   // divider step counter
  localparam int unsigned CenterW  = 11;  // centroid Q8, 0..1792
  localparam int unsigned RawW     = 7;   // raw error, -56..56
  localparam int unsigned FiltW    = 16;  // filter state, Q8
  localparam int unsigned DeltaW   = FiltW + 1;
  localparam int unsigned OutW     = 7;

  localparam logic signed [12:0]       CenterQ8   = 13'sd896;
  localparam logic signed [DeltaW-1:0] FastLimQ8  = 17'sd2560;  // 10 in Q8
  localparam int unsigned              SlowShift  = 3;

endpackage
`default_nettype wire

[rtl/lpef_scan.sv]
// Bit-serial scan of the sensor pattern: black channel count and index sum.
`timescale 1ns / 1ps
`default_nettype none
module lpef_scan
  import lpef_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [PatW-1:0] pattern_i,
  output logic                 done_o,
  output logic [SumW-1:0]      sum_o,
  output logic [CntW-1:0]      count_o
);

  logic            busy_q;
  logic            done_q;
  logic [PatW-1:0] pat_q;
  logic [IdxW-1:0] idx_q;
  logic [SumW-1:0] sum_q;
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (idx_q == IdxW'(PatW - 1))) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // one channel per cycle, LSB first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      pat_q <= pattern_i;
      idx_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
    end else if (busy_q) begin
      pat_q <= {1'b1, pat_q[PatW-1:1]};
      idx_q <= idx_q + 1'b1;
      if (!pat_q[0]) begin
        sum_q <= sum_q + SumW'(idx_q);
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign done_o  = done_q;
  assign sum_o   = sum_q;
  assign count_o = cnt_q;

endmodule
`default_nettype wire

[rtl/lpef_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lpef_div
  import lpef_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DvdW-1:0] dividend_i,
  input  wire logic [CntW-1:0] divisor_i,
  output logic                 done_o,
  output logic [DvdW-1:0]      quot_o
);

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] step_q;
  logic [DvdW-1:0]  dvd_q;
  logic [CntW-1:0]  dsr_q;
  logic [CntW-1:0]  rem_q;
  logic [CntW:0]    trial;
  logic             fits;

  // remainder stays below the divisor, so CntW+1 bits hold the trial value
  assign trial = {rem_q, dvd_q[DvdW-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (step_q == StepW'(DvdW - 1))) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      dsr_q  <= divisor_i;
      rem_q  <= '0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      dvd_q  <= {dvd_q[DvdW-2:0], fits};
      if (fits) begin
        rem_q <= CntW'(trial - {1'b0, dsr_q});
      end else begin
        rem_q <= trial[CntW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule
`default_nettype wire

[rtl/line_position_error_filter_top.sv]
// Top level of the line position error filter: control, filter state, output register.
`timescale 1ns / 1ps
`default_nettype none
// Takes one 8-bit line sensor pattern per item (a zero bit marks a black channel) and
// returns one item: the filtered line position error, integer part, -56..56, zero at
// centre. The pattern is scanned one channel per cycle, then the count and sum are
// handed over. The Q8 centroid is found by a restoring divider producing one
// quotient bit per cycle, then the raw error is registered (the divider is skipped when
// no channel is black). A filter step then updates the adaptive filter and loads the
// output register, waiting while the output register holds a result not yet taken.
// The serial divider is the longest step. The next item is accepted as soon as the
// filter has been updated, even while the previous result still waits in the output
// register. The first item after reset loads the filter directly.
module line_position_error_filter_top
  import lpef_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [PatW-1:0]        line_pattern_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic signed [OutW-1:0]      line_error_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StFilt = 2'd3;

  logic [1:0]             state_q, state_d;
  logic                   started_q;
  logic signed [FiltW-1:0] filt_q;
  logic signed [RawW-1:0] raw_q;
  logic                   out_valid_q;
  logic signed [OutW-1:0] out_q;

  logic                   in_acc;
  logic                   scan_done;
  logic [SumW-1:0]        scan_sum;
  logic [CntW-1:0]        scan_cnt;
  logic                   div_start;
  logic                   div_done;
  logic [DvdW-1:0]        div_quot;
  logic                   out_free;
  logic                   filt_go;

  // raw error from the centroid, truncated toward zero
  logic signed [12:0]      diff;
  logic [12:0]             diff_mag;
  logic [RawW-2:0]         raw_mag;
  logic signed [RawW-1:0]  raw_d;

  // filter update
  logic signed [FiltW-1:0]  target;
  logic signed [DeltaW-1:0] delta;
  logic signed [DeltaW-1:0] delta_mag;
  logic signed [DeltaW-1:0] step;
  logic signed [FiltW-1:0]  filt_d;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign filt_go    = (state_q == StFilt) && out_free;
  assign div_start  = scan_done && (scan_cnt != '0);

  lpef_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_acc),
    .pattern_i (line_pattern_i),
    .done_o    (scan_done),
    .sum_o     (scan_sum),
    .count_o   (scan_cnt)
  );

  lpef_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({scan_sum, 8'h00}),
    .divisor_i  (scan_cnt),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // centroid fits 11 bits, so the upper quotient bits are zero
  always_comb begin
    diff     = $signed({2'b00, div_quot[CenterW-1:0]}) - CenterQ8;
    diff_mag = diff[12] ? 13'(-diff) : 13'(diff);
    raw_mag  = diff_mag[9:4];
    raw_d    = diff[12] ? -$signed({1'b0, raw_mag}) : $signed({1'b0, raw_mag});
  end

  always_comb begin
    target    = FiltW'($signed({raw_q, 8'h00}));
    delta     = DeltaW'(target) - DeltaW'(filt_q);
    delta_mag = delta[DeltaW-1] ? -delta : delta;
    if (delta_mag >= FastLimQ8) begin
      step = delta >>> 1;
    end else begin
      step = delta >>> SlowShift;
    end
    if (!started_q) begin
      filt_d = target;
    end else begin
      filt_d = FiltW'(DeltaW'(filt_q) + step);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_acc) state_d = StScan;
      StScan: begin
        if (scan_done) state_d = (scan_cnt != '0) ? StDiv : StFilt;
      end
      StDiv:  if (div_done) state_d = StFilt;
      StFilt: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      started_q   <= 1'b0;
      filt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (filt_go) begin
        started_q   <= 1'b1;
        filt_q      <= filt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (scan_done && (scan_cnt == '0)) begin
      raw_q <= '0;  // all white: error is zero
    end else if (div_done) begin
      raw_q <= raw_d;
    end
    if (filt_go) begin
      out_q <= filt_d[FiltW-2:8];  // floor of Q8, range fits 7 bits
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_error_o = out_q;

  a_filt_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFilt) && !out_valid_q |=> out_valid_q && (state_q == StIdle))
    else $error("filter step did not load output");
  a_started_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("filter start flag fell");
  a_filt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (filt_q <= 16'sd14336) && (filt_q >= -16'sd14336))
    else $error("filter state out of range");
  a_scan_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |-> (state_q == StScan))
    else $error("scan finished outside scan state");
  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv))
    else $error("divide finished outside divide state");

endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the line position error filter top level.
`timescale 1ns / 1ps
module tb;
  import lpef_pkg::*;

  typedef logic signed [OutW-1:0] line_err_t;

  // Raw error scale: the Q8 centroid offset is divided by this, truncating toward zero.
  localparam int ErrScale = 16;

  // Scoreboard: mirrors the centroid and adaptive filter arithmetic and holds the
  // filtered errors still owed by the block, oldest first.
  class line_error_scoreboard;
    int        filt_q8;
    bit        started;
    line_err_t expected_errors[$];
    int        fail_count;

    function new();
      filt_q8    = 0;
      started    = 1'b0;
      fail_count = 0;
    endfunction

    // Called for every item the block accepts.
    function void note_pattern(logic [PatW-1:0] pat);
      int ch;
      int idx_sum;
      int black_cnt;
      int centre_q8;
      int raw_err;
      int delta;
      int delta_mag;
      idx_sum   = 0;
      black_cnt = 0;
      raw_err   = 0;
      for (ch = 0; ch < PatW; ch++) begin
        if (!pat[ch]) begin
          idx_sum   += ch;
          black_cnt += 1;
        end
      end
      // All white leaves the raw error at zero.
      if (black_cnt > 0) begin
        centre_q8 = (idx_sum * 256) / black_cnt;
        raw_err   = (centre_q8 - int'(CenterQ8)) / ErrScale;
      end
      if (!started) begin
        filt_q8 = raw_err * 256;
        started = 1'b1;
      end else begin
        delta     = raw_err * 256 - filt_q8;
        delta_mag = (delta < 0) ? -delta : delta;
        if (delta_mag >= int'(FastLimQ8)) begin
          filt_q8 += delta >>> 1;
        end else begin
          filt_q8 += delta >>> SlowShift;
        end
      end
      expected_errors.push_back(line_err_t'(filt_q8 >>> 8));
    endfunction

    // Called for every item the block hands out.
    function void check_error(line_err_t got);
      line_err_t want;
      if (expected_errors.size() == 0) begin
        $error("line_error: item with none outstanding, expected none, actual %0d", got);
        fail_count++;
        return;
      end
      want = expected_errors.pop_front();
      if (got !== want) begin
        $error("line_error mismatch: expected %0d, actual %0d", want, got);
        fail_count++;
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni         = 1'b0;
  logic            in_valid_i     = 1'b0;
  logic            in_ready_o;
  logic [PatW-1:0] line_pattern_i = '0;
  logic            out_valid_o;
  logic            out_ready_i    = 1'b0;
  line_err_t       line_error_o;

  line_error_scoreboard sb = new();

  int results_seen = 0;
  int track_pos    = 3;

  // Directed opening. The first item loads the filter directly, so it is taken off
  // centre (channel 0 alone) to tell a direct load from a filtered step. Then the
  // far extremes for the fast path, all white, all black, each single channel, a
  // repeated centre run that settles through the slow path, and a few odd shapes.
  logic [PatW-1:0] directed_patterns [0:23] = '{
    8'hFE, 8'h7F, 8'hFF, 8'h00, 8'hFD, 8'hFB, 8'hF7, 8'hEF,
    8'hDF, 8'hBF, 8'hE7, 8'hE7, 8'hE7, 8'hE7, 8'hE7, 8'hC3,
    8'h3C, 8'hF0, 8'h0F, 8'hAA, 8'h55, 8'hFC, 8'hFF, 8'hFE
  };

  line_position_error_filter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .line_pattern_i (line_pattern_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .line_error_o   (line_error_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Output monitor: sample at the rising edge, when out_ready_i is settled.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_error(line_error_o);
      results_seen <= results_seen + 1;
    end
  end

  // Offer one pattern, after an optional gap, and hold it until accepted. Entered and
  // left on a falling edge, so valid is only ever assigned once per time step.
  task automatic send_pattern(input logic [PatW-1:0] pat, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    line_pattern_i <= pat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_pattern(pat);
    @(negedge clk_i);
  endtask

  // Stop offering until every outstanding item has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.expected_errors.size() != 0);
  endtask

  // Random pattern: mostly a short black run drifting across the array, as a real
  // line would, so both filter paths get regular use; the rest is noise and the
  // all-white / all-black corners.
  function automatic logic [PatW-1:0] pick_pattern();
    logic [PatW-1:0] pat;
    int sel;
    int run_w;
    int b;
    sel = $urandom_range(0, 99);
    pat = '1;
    if (sel < 65) begin
      track_pos += $urandom_range(0, 2) - 1;
      if (sel < 8) track_pos = $urandom_range(0, PatW - 1);  // occasional jump
      if (track_pos < 0) track_pos = 0;
      if (track_pos > PatW - 1) track_pos = PatW - 1;
      run_w = $urandom_range(1, 3);
      for (b = 0; b < run_w; b++) begin
        if (track_pos + b < PatW) pat[track_pos + b] = 1'b0;
      end
    end else if (sel < 88) begin
      pat = PatW'($urandom);
    end else if (sel < 95) begin
      pat = '1;
    end else begin
      pat = '0;
    end
    return pat;
  endfunction

  // Sender: directed items, then random items in bursts with random gaps. Partway
  // through, it stops once to let the pipeline drain completely.
  initial begin
    int k;
    int burst_left;
    int gap;
    burst_left = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (k = 0; k < 24; k++) begin
      send_pattern(directed_patterns[k], $urandom_range(0, 3));
    end

    for (k = 0; k < 1030; k++) begin
      if (k == 600) wait_for_drain();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        // gaps long enough to land on any point of an item's processing
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      end else begin
        gap = 0;
      end
      burst_left--;
      send_pattern(pick_pattern(), gap);
    end

    in_valid_i <= 1'b0;
    while (sb.expected_errors.size() != 0) @(posedge clk_i);
    // allow for a stray late item
    repeat (40) @(posedge clk_i);

    if (sb.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: stretches of always-ready, coin-flip, and two periodic stall
  // patterns. Once, after a couple of hundred items, it holds off for a long while
  // so the output register fills and the block pushes back on its input.
  initial begin
    int mode;
    int stretch;
    int k;
    bit held;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(10, 120);
      for (k = 0; k < stretch; k++) begin
        @(negedge clk_i);
        if (!held && results_seen >= 200) begin
          held = 1'b1;
          out_ready_i <= 1'b0;
          repeat (200) @(negedge clk_i);
        end else begin
          case (mode)
            0: begin
              out_ready_i <= 1'b1;
            end
            1: begin
              out_ready_i <= 1'($urandom_range(0, 1));
            end
            2: begin
              out_ready_i <= (k % 4 != 3);
            end
            default: begin
              out_ready_i <= (k % 5 == 0);
            end
          endcase
        end
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
